### rtl/core/ray_box_slab_test_defines.svh
// ---------------------------------------------------------------------------
// Ray box slab test assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RBST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RBST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rbst_pkg.sv
// ---------------------------------------------------------------------------
// Ray box slab test package
// Widths, register indexes and the arithmetic helpers of the slab pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbst_pkg;

  localparam int CoordW   = 32;
  localparam int FracW    = 16;
  localparam int HalfW    = CoordW - 1;
  localparam int BoundW   = CoordW + 1;          // center +- half extent
  localparam int NumW     = CoordW + 2;          // bound - origin
  localparam int SegScale = 200;
  localparam int ScaleW   = 8;
  localparam int SegW     = CoordW + ScaleW;     // direction * 200
  localparam int DvdW     = NumW - 1 + FracW;    // dividend magnitude
  localparam int DvsW     = SegW - 1;            // divisor magnitude
  localparam int QuoW     = DvdW;
  localparam int TW       = 64;
  localparam int TBitW    = 44;                  // finite slab parameters fit here
  localparam int LoW      = 22;
  localparam int HiW      = TBitW - LoW;
  localparam int PlW      = CoordW + LoW + 1;
  localparam int PhW      = CoordW + HiW;
  localparam int ProdW    = CoordW + TBitW + 1;
  localparam int SpW      = ProdW + ScaleW;
  localparam int SatInW   = 80;
  localparam int CfgIdxW  = 3;

  localparam logic signed [TW-1:0] TUnbounded = 64'sh4000_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_HALF_X,
    REG_HALF_Y,
    REG_HALF_Z
  } reg_idx_t;

  typedef struct packed {
    logic [DvsW-1:0] rem;
    logic [DvdW-1:0] dvd;
    logic [QuoW-1:0] quo;
    logic [DvsW-1:0] dvs;
    logic            neg;
  } div_t;

  typedef struct packed {
    logic signed [CoordW-1:0] o;
    logic signed [CoordW-1:0] d;
    logic                     dzero;
    logic                     in_slab;
  } axis_t;

  // Sets up an unsigned restoring division of (num << FracW) by seg.
  function automatic div_t div_init(input logic signed [NumW-1:0] num,
                                    input logic signed [SegW-1:0] seg);
    div_t            r;
    logic [NumW-1:0] nabs;
    logic [SegW-1:0] sabs;
    nabs  = num[NumW-1] ? NumW'(-num) : NumW'(num);
    sabs  = seg[SegW-1] ? SegW'(-seg) : SegW'(seg);
    r.rem = '0;
    r.dvd = {nabs[NumW-2:0], {FracW{1'b0}}};
    r.quo = '0;
    r.dvs = sabs[DvsW-1:0];
    r.neg = num[NumW-1] ^ seg[SegW-1];
    return r;
  endfunction

  // One quotient bit of the restoring division.
  function automatic div_t div_step(input div_t s);
    div_t          r;
    logic [DvsW:0] trial;
    r     = s;
    trial = {s.rem, s.dvd[DvdW-1]};
    r.dvd = {s.dvd[DvdW-2:0], 1'b0};
    if (trial >= {1'b0, s.dvs}) begin
      r.rem = DvsW'(trial - {1'b0, s.dvs});
      r.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = trial[DvsW-1:0];
      r.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [SatInW-1:0] v);
    logic signed [SatInW-1:0] hi_lim;
    logic signed [SatInW-1:0] lo_lim;
    logic [CoordW-1:0]        r;
    hi_lim = SatInW'({1'b0, {(CoordW-1){1'b1}}});
    lo_lim = -hi_lim - SatInW'(1);
    if (v > hi_lim) begin
      r = hi_lim[CoordW-1:0];
    end else if (v < lo_lim) begin
      r = lo_lim[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/ray_box_slab_test.sv
// Throughput: one item per cycle while the output is not stalled.
// The 49 stage restoring divider sets the depth.
// The whole pipeline advances together and holds while a result waits unread.
// Reset clears all valid bits and loads the box registers with center 0 and
// half extents 1.0; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Ray box slab test
// Pipelined slab intersection of a scaled ray with one axis-aligned box.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_box_slab_test_defines.svh"

module ray_box_slab_test
  import rbst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [CoordW-1:0]     cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [6*CoordW-1:0]   s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit, t_enter, t_exit, enter_x, enter_y, enter_z, exit_x, exit_y, exit_z, zero pad
  output logic [8*CoordW+7:0]   m_tdata
);

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] t_enter;
    logic signed [CoordW-1:0] t_exit;
    logic signed [CoordW-1:0] enter_x;
    logic signed [CoordW-1:0] enter_y;
    logic signed [CoordW-1:0] enter_z;
    logic signed [CoordW-1:0] exit_x;
    logic signed [CoordW-1:0] exit_y;
    logic signed [CoordW-1:0] exit_z;
  } res_t;

  logic signed [CoordW-1:0] cen [3];
  logic [HalfW-1:0]         hlf [3];
  logic                     en;

  logic                     in_vld;
  logic signed [CoordW-1:0] in_o [3];
  logic signed [CoordW-1:0] in_d [3];

  div_t                     pr_dv [6];
  axis_t                    pr_ax [3];

  div_t                     dv    [QuoW+1][6];
  axis_t                    dv_ax [QuoW+1][3];
  logic [QuoW:0]            dv_vld;

  logic signed [TW-1:0]     f1_lo_next [3];
  logic signed [TW-1:0]     f1_hi_next [3];
  logic [2:0]               f1_ok_next;
  logic                     f1_vld;
  logic signed [TW-1:0]     f1_lo [3];
  logic signed [TW-1:0]     f1_hi [3];
  logic [2:0]               f1_ok;
  logic signed [CoordW-1:0] f1_o [3];
  logic signed [CoordW-1:0] f1_d [3];

  logic signed [TW-1:0]     f2_tin_next;
  logic signed [TW-1:0]     f2_tout_next;
  logic                     f2_vld;
  logic signed [TW-1:0]     f2_tin;
  logic signed [TW-1:0]     f2_tout;
  logic                     f2_ok;
  logic signed [CoordW-1:0] f2_o [3];
  logic signed [CoordW-1:0] f2_d [3];

  // Product index: axis * 2, plus one for the exit point.
  logic signed [PlW-1:0]    m1_pl_next [6];
  logic signed [PhW-1:0]    m1_ph_next [6];
  logic                     m1_vld;
  logic signed [PlW-1:0]    m1_pl [6];
  logic signed [PhW-1:0]    m1_ph [6];
  logic                     m1_ok;
  logic [CoordW-1:0]        m1_tin;
  logic [CoordW-1:0]        m1_tout;
  logic signed [CoordW-1:0] m1_o [3];

  logic                     m2_vld;
  logic signed [ProdW-1:0]  m2_p [6];
  logic                     m2_ok;
  logic [CoordW-1:0]        m2_tin;
  logic [CoordW-1:0]        m2_tout;
  logic signed [CoordW-1:0] m2_o [3];

  logic                     m3_vld;
  logic signed [SpW-1:0]    m3_sp [6];
  logic                     m3_ok;
  logic [CoordW-1:0]        m3_tin;
  logic [CoordW-1:0]        m3_tout;
  logic signed [CoordW-1:0] m3_o [3];

  logic [CoordW-1:0]        pt_next [6];
  res_t                     res;
  logic [QuoW+7:0]          pipe_vld;

  // -------------------------------------------------------------------------
  // Box registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cen[i] <= '0;
        hlf[i] <= HalfW'(1 << FracW);
      end
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X: cen[0] <= cfg_wdata;
        REG_CENTER_Y: cen[1] <= cfg_wdata;
        REG_CENTER_Z: cen[2] <= cfg_wdata;
        REG_HALF_X:   hlf[0] <= cfg_wdata[HalfW-1:0];
        REG_HALF_Y:   hlf[1] <= cfg_wdata[HalfW-1:0];
        REG_HALF_Z:   hlf[2] <= cfg_wdata[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // -------------------------------------------------------------------------
  // Valid chain
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      dv_vld   <= '0;
      f1_vld   <= 1'b0;
      f2_vld   <= 1'b0;
      m1_vld   <= 1'b0;
      m2_vld   <= 1'b0;
      m3_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      in_vld   <= s_tvalid;
      dv_vld   <= {dv_vld[QuoW-1:0], in_vld};
      f1_vld   <= dv_vld[QuoW];
      f2_vld   <= f1_vld;
      m1_vld   <= f2_vld;
      m2_vld   <= m1_vld;
      m3_vld   <= m2_vld;
      m_tvalid <= m3_vld;
    end
  end

  // -------------------------------------------------------------------------
  // Input register and slab setup
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        in_o[i] <= s_tdata[i*CoordW +: CoordW];
        in_d[i] <= s_tdata[(3+i)*CoordW +: CoordW];
      end
    end
  end

  always_comb begin
    logic signed [BoundW-1:0] mn;
    logic signed [BoundW-1:0] mx;
    logic signed [BoundW-1:0] oe;
    logic signed [NumW-1:0]   num_a;
    logic signed [NumW-1:0]   num_b;
    logic signed [SegW-1:0]   seg;
    for (int i = 0; i < 3; i++) begin
      mn    = $signed({cen[i][CoordW-1], cen[i]}) - $signed({2'b00, hlf[i]});
      mx    = $signed({cen[i][CoordW-1], cen[i]}) + $signed({2'b00, hlf[i]});
      oe    = $signed({in_o[i][CoordW-1], in_o[i]});
      num_a = $signed({mn[BoundW-1], mn}) - $signed({oe[BoundW-1], oe});
      num_b = $signed({mx[BoundW-1], mx}) - $signed({oe[BoundW-1], oe});
      seg   = $signed({{ScaleW{in_d[i][CoordW-1]}}, in_d[i]}) * $signed(SegW'(SegScale));
      pr_dv[2*i]       = div_init(num_a, seg);
      pr_dv[2*i+1]     = div_init(num_b, seg);
      pr_ax[i].o       = in_o[i];
      pr_ax[i].d       = in_d[i];
      pr_ax[i].dzero   = (in_d[i] == '0);
      pr_ax[i].in_slab = (oe >= mn) && (oe <= mx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]    <= pr_dv;
      dv_ax[0] <= pr_ax;
    end
  end

  // -------------------------------------------------------------------------
  // Divider: one quotient bit per stage for all six slab planes
  // -------------------------------------------------------------------------
  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 6; j++) begin
          dv[k][j] <= div_step(dv[k-1][j]);
        end
        dv_ax[k] <= dv_ax[k-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Signed parameters, per-axis ranges, then the overall range
  // -------------------------------------------------------------------------
  always_comb begin
    logic signed [TW-1:0] qm;
    logic signed [TW-1:0] qa;
    logic signed [TW-1:0] qb;
    for (int i = 0; i < 3; i++) begin
      qm = TW'(dv[QuoW][2*i].quo);
      qa = dv[QuoW][2*i].neg ? -qm : qm;
      qm = TW'(dv[QuoW][2*i+1].quo);
      qb = dv[QuoW][2*i+1].neg ? -qm : qm;
      if (dv_ax[QuoW][i].dzero) begin
        // A zero direction leaves this axis unbounded when the origin is inside.
        f1_lo_next[i] = -TUnbounded;
        f1_hi_next[i] = TUnbounded;
        f1_ok_next[i] = dv_ax[QuoW][i].in_slab;
      end else begin
        f1_lo_next[i] = (qa > qb) ? qb : qa;
        f1_hi_next[i] = (qa > qb) ? qa : qb;
        f1_ok_next[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_lo <= f1_lo_next;
      f1_hi <= f1_hi_next;
      f1_ok <= f1_ok_next;
      for (int i = 0; i < 3; i++) begin
        f1_o[i] <= dv_ax[QuoW][i].o;
        f1_d[i] <= dv_ax[QuoW][i].d;
      end
    end
  end

  always_comb begin
    f2_tin_next  = f1_lo[0];
    f2_tout_next = f1_hi[0];
    for (int i = 1; i < 3; i++) begin
      if (f1_lo[i] > f2_tin_next) begin
        f2_tin_next = f1_lo[i];
      end
      if (f1_hi[i] < f2_tout_next) begin
        f2_tout_next = f1_hi[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_tin  <= f2_tin_next;
      f2_tout <= f2_tout_next;
      f2_ok   <= (&f1_ok) && (f2_tin_next <= f2_tout_next);
      f2_o    <= f1_o;
      f2_d    <= f1_d;
    end
  end

  // -------------------------------------------------------------------------
  // Points: direction times parameter in two partial products, scale by 200,
  // floor shift, add the origin and saturate. When a parameter is unbounded
  // every direction is zero, so its truncated value never matters.
  // -------------------------------------------------------------------------
  always_comb begin
    logic signed [TBitW-1:0] tt;
    logic signed [PlW-1:0]   de_l;
    logic signed [PlW-1:0]   lo_s;
    logic signed [PhW-1:0]   de_h;
    logic signed [PhW-1:0]   hi_s;
    for (int j = 0; j < 6; j++) begin
      tt   = (j % 2 == 0) ? f2_tin[TBitW-1:0] : f2_tout[TBitW-1:0];
      de_l = PlW'(f2_d[j/2]);
      lo_s = PlW'({1'b0, tt[LoW-1:0]});
      de_h = PhW'(f2_d[j/2]);
      hi_s = PhW'($signed(tt[TBitW-1:LoW]));
      m1_pl_next[j] = de_l * lo_s;
      m1_ph_next[j] = de_h * hi_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_pl   <= m1_pl_next;
      m1_ph   <= m1_ph_next;
      m1_ok   <= f2_ok;
      m1_tin  <= sat_coord(SatInW'(f2_tin));
      m1_tout <= sat_coord(SatInW'(f2_tout));
      m1_o    <= f2_o;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        m2_p[j] <= (ProdW'(m1_ph[j]) <<< LoW) + ProdW'(m1_pl[j]);
      end
      m2_ok   <= m1_ok;
      m2_tin  <= m1_tin;
      m2_tout <= m1_tout;
      m2_o    <= m1_o;
    end
  end

  // The segment scale of 200 is 128 + 64 + 8.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        m3_sp[j] <= (SpW'(m2_p[j]) <<< 7) + (SpW'(m2_p[j]) <<< 6) + (SpW'(m2_p[j]) <<< 3);
      end
      m3_ok   <= m2_ok;
      m3_tin  <= m2_tin;
      m3_tout <= m2_tout;
      m3_o    <= m2_o;
    end
  end

  always_comb begin
    logic signed [SpW-1:0] sh;
    for (int j = 0; j < 6; j++) begin
      sh         = m3_sp[j] >>> FracW;
      pt_next[j] = sat_coord(SatInW'(sh) + SatInW'(m3_o[j/2]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (m3_ok) begin
        res.hit     <= 1'b1;
        res.t_enter <= m3_tin;
        res.t_exit  <= m3_tout;
        res.enter_x <= pt_next[0];
        res.exit_x  <= pt_next[1];
        res.enter_y <= pt_next[2];
        res.exit_y  <= pt_next[3];
        res.enter_z <= pt_next[4];
        res.exit_z  <= pt_next[5];
      end else begin
        res <= '0;
      end
    end
  end

  assign m_tdata = {7'b0, res.exit_z, res.exit_y, res.exit_x,
                    res.enter_z, res.enter_y, res.enter_x,
                    res.t_exit, res.t_enter, res.hit};

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  assign pipe_vld = {in_vld, dv_vld, f1_vld, f2_vld, m1_vld, m2_vld, m3_vld, m_tvalid};

  `RBST_ASSERT_NEXT(a_stall_holds_valids, !en, $stable(pipe_vld), "valids moved in a stall")
  `RBST_ASSERT_NOW(a_miss_zero, m_tvalid && !res.hit, res == '0, "miss item not zero")
  `RBST_ASSERT_NOW(a_hit_order, m_tvalid && res.hit, res.t_enter <= res.t_exit, "hit with entry after exit")
  `RBST_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid && !in_vld, "valid after reset")

endmodule

### test/tb_ray_box_slab_test.sv
// ---------------------------------------------------------------------------
// Ray box slab test bench
// Streams rays into the slab intersection pipeline, predicts each hit record
// in 64-bit integer arithmetic and compares it field by field on output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_box_slab_test
  import rbst_pkg::*;
();

  localparam int PipeLat    = 56;
  localparam int RandItems  = 800;
  localparam int CycleLimit = 400000;
  localparam longint TInf   = 64'sh4000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] exit_z, exit_y, exit_x, enter_z, enter_y, enter_x;
    logic [31:0] t_exit, t_enter;
    logic        hit;
  } hit_rec_t;

  typedef struct {
    logic [31:0] o[3];
    logic [31:0] d[3];
  } ray_t;

  typedef enum {ROW_RAY, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    ray_t        r;
    reg_idx_t    idx;
    logic [31:0] val;
    logic        has_exp;
    hit_rec_t    exp_rec;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [6*CoordW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [8*CoordW+7:0] m_tdata;

  longint box_c[3];
  longint box_h[3];
  hit_rec_t pending_hits[$];
  int errors = 0;
  int cycles = 0;
  int sink_idle = 0;
  bit quiet = 0;
  bit hold_sink = 0;

  ray_box_slab_test u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH %s at %0t", msg, $realtime);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s: got %h expected %h", what, got, want));
  endtask

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic int nbits(input longint v);
    longint unsigned m;
    int n;
    m = v < 0 ? -v : v;
    n = 0;
    while (m != 0) begin
      n++;
      m >>= 1;
    end
    return n;
  endfunction

  function automatic logic [31:0] along_ray(input longint o, input longint d, input longint t);
    if (d == 0 || t == 0) return clamp32(o);
    if (nbits(d) + nbits(t) > 62) return clamp32(((d < 0) != (t < 0)) ? -TInf : TInf);
    return clamp32(o + ((d * t) >>> 16));
  endfunction

  function automatic hit_rec_t slab_hit(input ray_t r);
    hit_rec_t res;
    longint o[3], d[3], lo[3], hi[3], a, b, mn, mx, tin, tout;
    bit ok;
    ok = 1;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(signed'(r.o[i]));
      d[i] = longint'(signed'(r.d[i])) * 200;
      mn = box_c[i] - box_h[i];
      mx = box_c[i] + box_h[i];
      if (d[i] == 0) begin
        lo[i] = -TInf;
        hi[i] = TInf;
        if (o[i] < mn || o[i] > mx) ok = 0;
      end else begin
        // SystemVerilog division truncates toward zero, as the slab needs.
        a = ((mn - o[i]) * 65536) / d[i];
        b = ((mx - o[i]) * 65536) / d[i];
        lo[i] = a < b ? a : b;
        hi[i] = a < b ? b : a;
      end
    end
    tin = lo[0];
    tout = hi[0];
    for (int i = 1; i < 3; i++) begin
      if (lo[i] > tin) tin = lo[i];
      if (hi[i] < tout) tout = hi[i];
    end
    if (tin > tout) ok = 0;
    res = '0;
    if (!ok) return res;
    res.hit = 1;
    res.t_enter = clamp32(tin);
    res.t_exit = clamp32(tout);
    res.enter_x = along_ray(o[0], d[0], tin);
    res.enter_y = along_ray(o[1], d[1], tin);
    res.enter_z = along_ray(o[2], d[2], tin);
    res.exit_x = along_ray(o[0], d[0], tout);
    res.exit_y = along_ray(o[1], d[1], tout);
    res.exit_z = along_ray(o[2], d[2], tout);
    return res;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx <= REG_CENTER_Z) box_c[idx] = longint'(signed'(val));
    else box_h[idx - REG_HALF_X] = longint'(val[30:0]);
  endtask

  task automatic drain;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (PipeLat + 5) @(negedge clk);
  endtask

  // Sends one ray; the caller is at a falling edge.
  task automatic send_ray(input ray_t r, input logic has_exp, input hit_rec_t want);
    hit_rec_t p;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tdata <= {r.d[2], r.d[1], r.d[0], r.o[2], r.o[1], r.o[0]};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    p = slab_hit(r);
    if (has_exp && p !== want) report("directed row disagrees with prediction");
    pending_hits.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = rand_coord();
      case ($urandom_range(0, 6))
        0: r.d[i] = 0;
        1: r.d[i] = $urandom;
        default: r.d[i] = 32'(signed'($urandom_range(0, 1024)) - 512);
      endcase
    end
    // Aim most rays at the box so hits dominate.
    if ($urandom_range(0, 2) != 0)
      for (int i = 0; i < 3; i++)
        r.d[i] = 32'((box_c[i] - longint'(signed'(r.o[i]))) / 200 / 65536 * 0 +
                     ((box_c[i] - longint'(signed'(r.o[i]))) >>> 8)) + $urandom_range(0, 7);
    return r;
  endfunction

  // Output side: random idle bursts and one long hold-off.
  always @(negedge clk) begin
    if (rst || hold_sink) begin
      m_tready <= 0;
    end else if (sink_idle > 0) begin
      m_tready <= 0;
      sink_idle <= sink_idle - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready <= 0;
      sink_idle <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    hit_rec_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = hit_rec_t'(m_tdata[8*CoordW:0]);
      if (pending_hits.size() == 0) begin
        report("unexpected result");
      end else begin
        want = pending_hits.pop_front();
        check_field("hit", 32'(got.hit), 32'(want.hit));
        check_field("t_enter", got.t_enter, want.t_enter);
        check_field("t_exit", got.t_exit, want.t_exit);
        check_field("enter_x", got.enter_x, want.enter_x);
        check_field("enter_y", got.enter_y, want.enter_y);
        check_field("enter_z", got.enter_z, want.enter_z);
        check_field("exit_x", got.exit_x, want.exit_x);
        check_field("exit_y", got.exit_y, want.exit_y);
        check_field("exit_z", got.exit_z, want.exit_z);
      end
    end
  end

  function automatic row_t ray_row(input logic [31:0] ox, input logic [31:0] oy,
                                   input logic [31:0] oz, input logic [31:0] dx,
                                   input logic [31:0] dy, input logic [31:0] dz);
    row_t w;
    w.kind = ROW_RAY;
    w.r.o[0] = ox; w.r.o[1] = oy; w.r.o[2] = oz;
    w.r.d[0] = dx; w.r.d[1] = dy; w.r.d[2] = dz;
    w.has_exp = 0;
    w.exp_rec = '0;
    w.idx = REG_CENTER_X;
    w.val = 0;
    return w;
  endfunction

  function automatic row_t miss_row(input row_t w);
    w.has_exp = 1;
    w.exp_rec = '0;
    return w;
  endfunction

  initial begin
    row_t rows[$];
    row_t w;
    hit_rec_t e;
    ray_t r;
    logic [31:0] v;
    box_c = '{0, 0, 0};
    box_h = '{65536, 65536, 65536};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Ray along +x from x = -2 through the unit box.
    rows.push_back(ray_row(32'hfffe_0000, 0, 0, 32'h0000_0100, 0, 0));
    // All directions zero, origin inside: unbounded parameters, points at origin.
    w = ray_row(32'h0000_8000, 0, 0, 0, 0, 0);
    e = '0;
    e.hit = 1; e.t_enter = 32'h8000_0000; e.t_exit = 32'h7fff_ffff;
    e.enter_x = 32'h0000_8000; e.exit_x = 32'h0000_8000;
    w.has_exp = 1; w.exp_rec = e;
    rows.push_back(w);
    // Origin exactly on a bound with zero direction counts as inside.
    rows.push_back(ray_row(32'h0001_0000, 32'hffff_0000, 0, 0, 0, 32'h0000_0010));
    // Zero direction with origin outside the slab misses.
    rows.push_back(miss_row(ray_row(32'h0002_0000, 0, 0, 0, 32'h0000_0100, 0)));
    // Ray almost parallel to the box passing beside it misses.
    rows.push_back(miss_row(ray_row(32'hfffe_0000, 32'h0001_0000, 32'h0003_0000,
                                    32'h0000_0100, 32'h0000_0000, 32'h0000_0001)));
    // Entry behind the origin, exit beyond the segment end.
    rows.push_back(ray_row(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    rows.push_back(ray_row(0, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    rows.push_back(ray_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    rows.push_back(ray_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    rows.push_back(ray_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1));
    // Largest box at the extremes of the registers.
    w.kind = ROW_REG; w.has_exp = 0;
    w.idx = REG_HALF_X; w.val = 32'h7fff_ffff; rows.push_back(w);
    w.idx = REG_HALF_Y; w.val = 32'h7fff_ffff; rows.push_back(w);
    w.idx = REG_HALF_Z; w.val = 32'h7fff_ffff; rows.push_back(w);
    w.idx = REG_CENTER_X; w.val = 32'h8000_0000; rows.push_back(w);
    w.idx = REG_CENTER_Y; w.val = 32'h7fff_ffff; rows.push_back(w);
    w.idx = REG_CENTER_Z; w.val = 32'h0000_0000; rows.push_back(w);
    rows.push_back(ray_row(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0000_0001, 0, 32'hffff_ffff));
    rows.push_back(ray_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 0));
    // Zero-size box.
    w.kind = ROW_REG;
    w.idx = REG_HALF_X; w.val = 0; rows.push_back(w);
    w.idx = REG_HALF_Y; w.val = 0; rows.push_back(w);
    w.idx = REG_HALF_Z; w.val = 0; rows.push_back(w);
    w.idx = REG_CENTER_X; w.val = 0; rows.push_back(w);
    w.idx = REG_CENTER_Y; w.val = 0; rows.push_back(w);
    rows.push_back(ray_row(32'hffff_0000, 32'hffff_0000, 32'hffff_0000, 1, 1, 1));
    rows.push_back(ray_row(0, 0, 0, 0, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        if (i == 0 || rows[i-1].kind == ROW_RAY) begin
          s_tvalid <= 0;
          drain();
        end
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_ray(rows[i].r, rows[i].has_exp, rows[i].exp_rec);
      end
    end
    s_tvalid <= 0;

    // Random phases, each with a fresh box.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      for (int k = 0; k < 6; k++) begin
        if (k < 3) v = (ph == 7) ? $urandom : 32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16));
        else v = (ph == 6) ? $urandom : $urandom_range(0, 3 << 16);
        write_reg(reg_idx_t'(k), v);
      end
      if (ph == 2) begin
        hold_sink = 1;
        fork
          begin
            repeat (200) @(negedge clk);
            hold_sink = 0;
          end
        join_none
      end
      if (ph == 7) quiet = 1;
      for (int n = 0; n < RandItems / 8; n++) begin
        r = rand_ray();
        send_ray(r, 0, '0);
      end
      s_tvalid <= 0;
    end

    while (pending_hits.size() != 0) @(negedge clk);
    repeat (PipeLat + 10) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
